// ===== design/cpcr_pkg.sv =====
// ----------------------------------------------------------------------------
// cpcr_pkg
// Shared types, register codes and helpers for the circle pair collision
// resolve core.
// ----------------------------------------------------------------------------
package cpcr_pkg;

	localparam int unsigned POS_W  = 32;
	localparam int unsigned RSUM_W = 31;
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		REG_CONTACT_EPS    = 2'd0,
		REG_DAMPING        = 2'd1,
		REG_DIFFUSION_RATE = 2'd2,
		REG_FIRE_ENABLE    = 2'd3
	} reg_idx_t;

	localparam logic [1:0] OUT_COINCIDENT = 2'd0;
	localparam logic [1:0] OUT_NO_OVERLAP = 2'd1;
	localparam logic [1:0] OUT_RESOLVED   = 2'd2;

	typedef struct packed {
		logic [15:0] contact_eps;
		logic [15:0] damping;
		logic [16:0] diffusion_rate;
		logic        fire_enable;
	} cfg_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_a_x;
		logic signed [POS_W-1:0] pos_a_y;
		logic signed [POS_W-1:0] prev_a_x;
		logic signed [POS_W-1:0] prev_a_y;
		logic signed [POS_W-1:0] pos_b_x;
		logic signed [POS_W-1:0] pos_b_y;
		logic signed [POS_W-1:0] prev_b_x;
		logic signed [POS_W-1:0] prev_b_y;
		logic [RSUM_W-1:0]       radius_sum;
		logic [1:0]              fixed_flags;
		logic signed [POS_W-1:0] temp_a;
		logic signed [POS_W-1:0] temp_b;
	} item_t;

	// geometry carried alongside the square root
	typedef struct packed {
		item_t              item;
		logic               sx;
		logic               sy;
		logic [30:0]        ax;
		logic [30:0]        ay;
		logic               coinc;
		logic               far;
		logic signed [32:0] gap;
	} geo_t;

	// contact data carried alongside the normal divider
	typedef struct packed {
		item_t              item;
		logic               sx;
		logic               sy;
		logic [30:0]        overlap;
		logic               coinc;
		logic               resolve;
		logic signed [32:0] gap;
	} cont_t;

	function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
		if (v > 37'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -37'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

endpackage

// ===== design/cpcr_regs.sv =====
// ----------------------------------------------------------------------------
// cpcr_regs
// APB-style configuration registers of the collision resolve core.
// ----------------------------------------------------------------------------
module cpcr_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cpcr_pkg::ADDR_W-1:0]   paddr,
	input  logic [cpcr_pkg::DATA_W-1:0]   pwdata,
	output logic [cpcr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output cpcr_pkg::cfg_t                cfg
);

	cpcr_pkg::cfg_t     cfg_q;
	cpcr_pkg::reg_idx_t idx;
	logic               wr;

	assign idx    = cpcr_pkg::reg_idx_t'(paddr[3:2]);
	assign wr     = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.contact_eps    <= 16'd66;
			cfg_q.damping        <= 16'd32440;
			cfg_q.diffusion_rate <= 17'd6554;
			cfg_q.fire_enable    <= 1'b0;
		end else if (wr) begin
			case (idx)
				cpcr_pkg::REG_CONTACT_EPS:    cfg_q.contact_eps    <= pwdata[15:0];
				cpcr_pkg::REG_DAMPING:        cfg_q.damping        <= pwdata[15:0];
				cpcr_pkg::REG_DIFFUSION_RATE: cfg_q.diffusion_rate <= pwdata[16:0];
				cpcr_pkg::REG_FIRE_ENABLE:    cfg_q.fire_enable    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			cpcr_pkg::REG_CONTACT_EPS:    prdata = {16'd0, cfg_q.contact_eps};
			cpcr_pkg::REG_DAMPING:        prdata = {16'd0, cfg_q.damping};
			cpcr_pkg::REG_DIFFUSION_RATE: prdata = {15'd0, cfg_q.diffusion_rate};
			cpcr_pkg::REG_FIRE_ENABLE:    prdata = {31'd0, cfg_q.fire_enable};
			default:                      prdata = '0;
		endcase
	end

endmodule

// ===== design/cpcr_isqrt.sv =====
// ----------------------------------------------------------------------------
// cpcr_isqrt
// Pipelined integer square root of a 63-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module cpcr_isqrt #(
	parameter int unsigned SB_W = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  logic [62:0]     in_rad,
	input  logic [SB_W-1:0] in_sb,
	output logic            out_vld,
	output logic [31:0]     out_root,
	output logic [SB_W-1:0] out_sb
);

	localparam int unsigned STEPS = 32;

	logic            vld_s  [STEPS];
	logic [62:0]     rem_s  [STEPS];
	logic [63:0]     root_s [STEPS];
	logic [SB_W-1:0] sb_s   [STEPS];

	genvar k;
	generate
		for (k = 0; k < STEPS; k++) begin : g_step
			localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
			logic            v_in;
			logic [62:0]     r_in;
			logic [63:0]     q_in;
			logic [SB_W-1:0] b_in;
			logic [63:0]     trial;
			logic [62:0]     r_nx;
			logic [63:0]     q_nx;

			if (k == 0) begin : g_first
				assign v_in = in_vld;
				assign r_in = in_rad;
				assign q_in = '0;
				assign b_in = in_sb;
			end else begin : g_next
				assign v_in = vld_s[k-1];
				assign r_in = rem_s[k-1];
				assign q_in = root_s[k-1];
				assign b_in = sb_s[k-1];
			end

			always_comb begin
				trial = q_in + BIT;
				if ({1'b0, r_in} >= trial) begin
					r_nx = r_in - trial[62:0];
					q_nx = (q_in >> 1) + BIT;
				end else begin
					r_nx = r_in;
					q_nx = q_in >> 1;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (en) begin
					vld_s[k] <= v_in;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k]  <= r_nx;
					root_s[k] <= q_nx;
					sb_s[k]   <= b_in;
				end
			end
		end
	endgenerate

	assign out_vld  = vld_s[STEPS-1];
	assign out_root = root_s[STEPS-1][31:0];
	assign out_sb   = sb_s[STEPS-1];

endmodule

// ===== design/cpcr_divider.sv =====
// ----------------------------------------------------------------------------
// cpcr_divider
// Two-lane pipelined restoring divider for the unit normal: q = num*2^F/den,
// one quotient bit per stage, for num not above den.
// ----------------------------------------------------------------------------
module cpcr_divider #(
	parameter int unsigned FRAC_BITS = 16,
	parameter int unsigned SB_W      = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic [30:0]        num_x,
	input  logic [30:0]        num_y,
	input  logic [30:0]        den,
	input  logic [SB_W-1:0]    in_sb,
	output logic               out_vld,
	output logic [FRAC_BITS:0] quo_x,
	output logic [FRAC_BITS:0] quo_y,
	output logic [SB_W-1:0]    out_sb
);

	localparam int unsigned STEPS = FRAC_BITS + 1;

	logic               vld_s [STEPS];
	logic [30:0]        den_s [STEPS];
	logic [30:0]        rem_s [STEPS][2];
	logic [FRAC_BITS:0] quo_s [STEPS][2];
	logic [SB_W-1:0]    sb_s  [STEPS];

	genvar j;
	generate
		for (j = 0; j < STEPS; j++) begin : g_step
			logic               v_in;
			logic [30:0]        d_in;
			logic [30:0]        r_in [2];
			logic [FRAC_BITS:0] q_in [2];
			logic [SB_W-1:0]    b_in;
			logic [31:0]        shf  [2];
			logic [30:0]        r_nx [2];
			logic [FRAC_BITS:0] q_nx [2];

			if (j == 0) begin : g_first
				assign v_in    = in_vld;
				assign d_in    = den;
				assign r_in[0] = num_x;
				assign r_in[1] = num_y;
				assign q_in[0] = '0;
				assign q_in[1] = '0;
				assign b_in    = in_sb;
			end else begin : g_next
				assign v_in    = vld_s[j-1];
				assign d_in    = den_s[j-1];
				assign r_in[0] = rem_s[j-1][0];
				assign r_in[1] = rem_s[j-1][1];
				assign q_in[0] = quo_s[j-1][0];
				assign q_in[1] = quo_s[j-1][1];
				assign b_in    = sb_s[j-1];
			end

			always_comb begin
				for (int l = 0; l < 2; l++) begin
					// first step takes the integer bit without a shift
					shf[l]  = (j == 0) ? {1'b0, r_in[l]} : {r_in[l], 1'b0};
					q_nx[l] = q_in[l];
					if (shf[l] >= {1'b0, d_in}) begin
						r_nx[l] = 31'(shf[l] - {1'b0, d_in});
						q_nx[l][FRAC_BITS-j] = 1'b1;
					end else begin
						r_nx[l] = shf[l][30:0];
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[j] <= 1'b0;
				end else if (en) begin
					vld_s[j] <= v_in;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					den_s[j]    <= d_in;
					rem_s[j][0] <= r_nx[0];
					rem_s[j][1] <= r_nx[1];
					quo_s[j][0] <= q_nx[0];
					quo_s[j][1] <= q_nx[1];
					sb_s[j]     <= b_in;
				end
			end
		end
	endgenerate

	assign out_vld = vld_s[STEPS-1];
	assign quo_x   = quo_s[STEPS-1][0];
	assign quo_y   = quo_s[STEPS-1][1];
	assign out_sb  = sb_s[STEPS-1];

endmodule

// ===== design/circle_pair_collision_resolve_core.sv =====
// ----------------------------------------------------------------------------
// circle_pair_collision_resolve_core
// Resolves the contact of one pair of circular Verlet particles in Q16.16.
// ----------------------------------------------------------------------------
// Usage: present one particle pair per transaction on the in_* channel
// (valid/ready); the resolved pair leaves on the out_* channel with an outcome
// code (coincident centres, no overlap, resolved). Results come out in order,
// one per input transaction.
// Pipeline: the 32-stage square root and the FRAC_BITS+1-stage normal divider,
// plus input, delta, square, sum, overlap, push multiply, move, damping
// multiply and output stages.
// Throughput: one pair per cycle while the output is not stalled.
// Stall: the whole pipeline holds while out_valid is high and out_ready low;
// in_ready drops in that cycle, so nothing is lost or repeated.
// Reset: all stage valid bits clear; the registers return to contact_eps 66,
// damping 32440, diffusion_rate 6554, fire_enable 0.
// Configuration: APB-style port, write registers only while idle.
// ----------------------------------------------------------------------------
module circle_pair_collision_resolve_core #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cpcr_pkg::ADDR_W-1:0] paddr,
	input  logic [cpcr_pkg::DATA_W-1:0] pwdata,
	output logic [cpcr_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	// input channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [31:0]          pos_a_x,
	input  logic signed [31:0]          pos_a_y,
	input  logic signed [31:0]          prev_a_x,
	input  logic signed [31:0]          prev_a_y,
	input  logic signed [31:0]          pos_b_x,
	input  logic signed [31:0]          pos_b_y,
	input  logic signed [31:0]          prev_b_x,
	input  logic signed [31:0]          prev_b_y,
	input  logic [30:0]                 radius_sum,
	input  logic [1:0]                  fixed_flags,
	input  logic signed [31:0]          temp_a,
	input  logic signed [31:0]          temp_b,
	// output channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [31:0]          new_pos_a_x,
	output logic signed [31:0]          new_pos_a_y,
	output logic signed [31:0]          new_prev_a_x,
	output logic signed [31:0]          new_prev_a_y,
	output logic signed [31:0]          new_pos_b_x,
	output logic signed [31:0]          new_pos_b_y,
	output logic signed [31:0]          new_prev_b_x,
	output logic signed [31:0]          new_prev_b_y,
	output logic signed [31:0]          new_temp_a,
	output logic signed [31:0]          new_temp_b,
	output logic [1:0]                  outcome
);

	localparam int unsigned GEO_W  = $bits(cpcr_pkg::geo_t);
	localparam int unsigned CONT_W = $bits(cpcr_pkg::cont_t);
	localparam int unsigned MUL_W  = FRAC_BITS + 32;

	cpcr_pkg::cfg_t cfg;
	logic           en;

	// one global advance: every stage moves together or holds together
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	cpcr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ---- s1: register the input transaction ----
	cpcr_pkg::item_t item_in, item_s1;
	logic            vld_s1;

	always_comb begin
		item_in.pos_a_x     = pos_a_x;
		item_in.pos_a_y     = pos_a_y;
		item_in.prev_a_x    = prev_a_x;
		item_in.prev_a_y    = prev_a_y;
		item_in.pos_b_x     = pos_b_x;
		item_in.pos_b_y     = pos_b_y;
		item_in.prev_b_x    = prev_b_x;
		item_in.prev_b_y    = prev_b_y;
		item_in.radius_sum  = radius_sum;
		item_in.fixed_flags = fixed_flags;
		item_in.temp_a      = temp_a;
		item_in.temp_b      = temp_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) item_s1 <= item_in;
	end

	// ---- s2: center deltas, special cases, temperature gap ----
	cpcr_pkg::geo_t     geo_c, geo_s2, geo_s3, geo_s4;
	logic signed [32:0] dx_c, dy_c;
	logic [32:0]        adx_c, ady_c;
	logic               vld_s2, vld_s3, vld_s4;

	always_comb begin
		dx_c  = {item_s1.pos_b_x[31], item_s1.pos_b_x} - {item_s1.pos_a_x[31], item_s1.pos_a_x};
		dy_c  = {item_s1.pos_b_y[31], item_s1.pos_b_y} - {item_s1.pos_a_y[31], item_s1.pos_a_y};
		adx_c = dx_c[32] ? 33'(-dx_c) : dx_c;
		ady_c = dy_c[32] ? 33'(-dy_c) : dy_c;
		geo_c.item  = item_s1;
		geo_c.sx    = dx_c[32];
		geo_c.sy    = dy_c[32];
		geo_c.ax    = adx_c[30:0];
		geo_c.ay    = ady_c[30:0];
		geo_c.coinc = (dx_c == '0) && (dy_c == '0);
		// a delta of 2^31 or more can never be inside radius_sum
		geo_c.far   = adx_c[32] || adx_c[31] || ady_c[32] || ady_c[31];
		geo_c.gap   = {item_s1.temp_a[31], item_s1.temp_a} - {item_s1.temp_b[31], item_s1.temp_b};
	end

	// ---- s3: squares, s4: sum of squares ----
	logic [61:0] sqx_s3, sqy_s3;
	logic [62:0] sq_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s2 <= geo_c;
			sqx_s3 <= geo_s2.ax * geo_s2.ax;
			sqy_s3 <= geo_s2.ay * geo_s2.ay;
			geo_s3 <= geo_s2;
			sq_s4  <= {1'b0, sqx_s3} + {1'b0, sqy_s3};
			geo_s4 <= geo_s3;
		end
	end

	// ---- square root: center distance ----
	logic           sq_vld;
	logic [31:0]    ctr_dist;
	cpcr_pkg::geo_t geo_sq;

	cpcr_isqrt #(
		.SB_W (GEO_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4),
		.in_rad   (sq_s4),
		.in_sb    (geo_s4),
		.out_vld  (sq_vld),
		.out_root (ctr_dist),
		.out_sb   (geo_sq)
	);

	// ---- s5: overlap and contact decision ----
	cpcr_pkg::cont_t    cont_c, cont_s5;
	logic signed [32:0] ovl_c;
	logic [30:0]        ax_s5, ay_s5, dist_s5;
	logic               vld_s5;

	always_comb begin
		ovl_c = {2'b00, geo_sq.item.radius_sum} - {1'b0, ctr_dist};
		cont_c.item    = geo_sq.item;
		cont_c.sx      = geo_sq.sx;
		cont_c.sy      = geo_sq.sy;
		cont_c.overlap = ovl_c[30:0];
		cont_c.coinc   = geo_sq.coinc;
		cont_c.resolve = !geo_sq.coinc && !geo_sq.far && (ctr_dist != '0) && !ovl_c[32]
			&& (ovl_c[31:0] >= {16'd0, cfg.contact_eps});
		cont_c.gap     = geo_sq.gap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cont_s5 <= cont_c;
			ax_s5   <= geo_sq.ax;
			ay_s5   <= geo_sq.ay;
			dist_s5 <= ctr_dist[30:0];
		end
	end

	// ---- divider: unit normal magnitudes ----
	logic               dv_vld;
	logic [FRAC_BITS:0] qx, qy;
	cpcr_pkg::cont_t    cont_dv;

	cpcr_divider #(
		.FRAC_BITS (FRAC_BITS),
		.SB_W      (CONT_W)
	) u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s5),
		.num_x   (ax_s5),
		.num_y   (ay_s5),
		.den     (dist_s5),
		.in_sb   (cont_s5),
		.out_vld (dv_vld),
		.quo_x   (qx),
		.quo_y   (qy),
		.out_sb  (cont_dv)
	);

	// ---- s6: push and heat multiplies ----
	logic [30:0]     amount_c;
	logic [32:0]     agap_c;
	logic [MUL_W-1:0] mx_s6, my_s6;
	logic [48:0]     tp_s6;
	logic            heat_s6;
	cpcr_pkg::cont_t cont_s6;
	logic            vld_s6;

	always_comb begin
		// full overlap when either particle is pinned, else split it
		amount_c = (cont_dv.item.fixed_flags != 2'b00) ? cont_dv.overlap
		                                               : (cont_dv.overlap >> 1);
		agap_c   = cont_dv.gap[32] ? 33'(-cont_dv.gap) : cont_dv.gap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s6   <= MUL_W'(qx * amount_c);
			my_s6   <= MUL_W'(qy * amount_c);
			tp_s6   <= agap_c[32:1] * cfg.diffusion_rate;
			heat_s6 <= cfg.fire_enable && cont_dv.resolve
				&& (agap_c > {17'd0, cfg.contact_eps});
			cont_s6 <= cont_dv;
		end
	end

	// ---- s7: new positions and temperatures ----
	logic signed [31:0] pos_c  [4];
	logic               neg_c  [4];
	logic               mov_c  [4];
	logic [30:0]        cmag_c [4];
	logic signed [31:0] np_c   [4];
	logic [32:0]        t_c;
	logic signed [31:0] nta_c, ntb_c;
	logic signed [31:0] np_s7  [4];
	logic               mov_s7 [4];
	logic signed [31:0] nta_s7, ntb_s7;
	cpcr_pkg::cont_t    cont_s7;
	logic               vld_s7;

	always_comb begin
		// lanes: A.x, A.y, B.x, B.y
		pos_c[0]  = cont_s6.item.pos_a_x;
		pos_c[1]  = cont_s6.item.pos_a_y;
		pos_c[2]  = cont_s6.item.pos_b_x;
		pos_c[3]  = cont_s6.item.pos_b_y;
		cmag_c[0] = mx_s6[FRAC_BITS+30:FRAC_BITS];
		cmag_c[1] = my_s6[FRAC_BITS+30:FRAC_BITS];
		cmag_c[2] = mx_s6[FRAC_BITS+30:FRAC_BITS];
		cmag_c[3] = my_s6[FRAC_BITS+30:FRAC_BITS];
		// A steps against the normal, B along it
		neg_c[0]  = !cont_s6.sx;
		neg_c[1]  = !cont_s6.sy;
		neg_c[2]  = cont_s6.sx;
		neg_c[3]  = cont_s6.sy;
		mov_c[0]  = cont_s6.resolve && !cont_s6.item.fixed_flags[0];
		mov_c[1]  = mov_c[0];
		mov_c[2]  = cont_s6.resolve && !cont_s6.item.fixed_flags[1];
		mov_c[3]  = mov_c[2];
		for (int l = 0; l < 4; l++) begin
			np_c[l] = neg_c[l]
				? cpcr_pkg::sat32({{5{pos_c[l][31]}}, pos_c[l]} - {6'd0, cmag_c[l]})
				: cpcr_pkg::sat32({{5{pos_c[l][31]}}, pos_c[l]} + {6'd0, cmag_c[l]});
		end
		t_c = tp_s6[48:16];
		// heat flows from the hotter particle to the colder one
		if (!heat_s6) begin
			nta_c = cont_s6.item.temp_a;
			ntb_c = cont_s6.item.temp_b;
		end else if (!cont_s6.gap[32]) begin
			nta_c = cpcr_pkg::sat32({{5{cont_s6.item.temp_a[31]}}, cont_s6.item.temp_a}
				- {4'd0, t_c});
			ntb_c = cpcr_pkg::sat32({{5{cont_s6.item.temp_b[31]}}, cont_s6.item.temp_b}
				+ {4'd0, t_c});
		end else begin
			nta_c = cpcr_pkg::sat32({{5{cont_s6.item.temp_a[31]}}, cont_s6.item.temp_a}
				+ {4'd0, t_c});
			ntb_c = cpcr_pkg::sat32({{5{cont_s6.item.temp_b[31]}}, cont_s6.item.temp_b}
				- {4'd0, t_c});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			np_s7   <= np_c;
			mov_s7  <= mov_c;
			nta_s7  <= nta_c;
			ntb_s7  <= ntb_c;
			cont_s7 <= cont_s6;
		end
	end

	// ---- s8: velocity times damping ----
	logic signed [31:0] prv_c  [4];
	logic signed [32:0] vel_c  [4];
	logic [32:0]        vmag_c [4];
	logic signed [31:0] np_s8  [4];
	logic               mov_s8 [4];
	logic               vneg_s8 [4];
	logic [48:0]        vp_s8  [4];
	logic signed [31:0] nta_s8, ntb_s8;
	cpcr_pkg::cont_t    cont_s8;
	logic               vld_s8;

	always_comb begin
		prv_c[0] = cont_s7.item.prev_a_x;
		prv_c[1] = cont_s7.item.prev_a_y;
		prv_c[2] = cont_s7.item.prev_b_x;
		prv_c[3] = cont_s7.item.prev_b_y;
		for (int l = 0; l < 4; l++) begin
			vel_c[l]  = {np_s7[l][31], np_s7[l]} - {prv_c[l][31], prv_c[l]};
			vmag_c[l] = vel_c[l][32] ? 33'(-vel_c[l]) : vel_c[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				vp_s8[l]   <= vmag_c[l] * cfg.damping;
				vneg_s8[l] <= vel_c[l][32];
			end
			np_s8   <= np_s7;
			mov_s8  <= mov_s7;
			nta_s8  <= nta_s7;
			ntb_s8  <= ntb_s7;
			cont_s8 <= cont_s7;
		end
	end

	// ---- s9: new previous positions, output register ----
	logic [33:0]        dmag_c [4];
	logic signed [31:0] npv_c  [4];
	logic signed [31:0] opos_c [4];
	logic signed [31:0] oprv_c [4];
	logic signed [31:0] opos_s9 [4];
	logic signed [31:0] oprv_s9 [4];
	logic signed [31:0] nta_s9, ntb_s9;
	logic [1:0]         outc_s9;
	cpcr_pkg::item_t    item_s9;
	logic               vld_s9;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			dmag_c[l] = vp_s8[l][48:15];
			// subtracting a negative damped velocity adds its magnitude
			npv_c[l] = vneg_s8[l]
				? cpcr_pkg::sat32({{5{np_s8[l][31]}}, np_s8[l]} + {3'd0, dmag_c[l]})
				: cpcr_pkg::sat32({{5{np_s8[l][31]}}, np_s8[l]} - {3'd0, dmag_c[l]});
		end
		opos_c[0] = cont_s8.item.pos_a_x;
		opos_c[1] = cont_s8.item.pos_a_y;
		opos_c[2] = cont_s8.item.pos_b_x;
		opos_c[3] = cont_s8.item.pos_b_y;
		oprv_c[0] = cont_s8.item.prev_a_x;
		oprv_c[1] = cont_s8.item.prev_a_y;
		oprv_c[2] = cont_s8.item.prev_b_x;
		oprv_c[3] = cont_s8.item.prev_b_y;
		for (int l = 0; l < 4; l++) begin
			if (mov_s8[l]) begin
				opos_c[l] = np_s8[l];
				oprv_c[l] = npv_c[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			opos_s9 <= opos_c;
			oprv_s9 <= oprv_c;
			nta_s9  <= nta_s8;
			ntb_s9  <= ntb_s8;
			item_s9 <= cont_s8.item;
			if (cont_s8.coinc)
				outc_s9 <= cpcr_pkg::OUT_COINCIDENT;
			else if (cont_s8.resolve)
				outc_s9 <= cpcr_pkg::OUT_RESOLVED;
			else
				outc_s9 <= cpcr_pkg::OUT_NO_OVERLAP;
		end
	end

	assign out_valid    = vld_s9;
	assign new_pos_a_x  = opos_s9[0];
	assign new_pos_a_y  = opos_s9[1];
	assign new_pos_b_x  = opos_s9[2];
	assign new_pos_b_y  = opos_s9[3];
	assign new_prev_a_x = oprv_s9[0];
	assign new_prev_a_y = oprv_s9[1];
	assign new_prev_b_x = oprv_s9[2];
	assign new_prev_b_y = oprv_s9[3];
	assign new_temp_a   = nta_s9;
	assign new_temp_b   = ntb_s9;
	assign outcome      = outc_s9;

	// ---- assertions ----
	// an accepted transaction lands in the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s1)
		else $error("accepted transaction did not enter the pipeline");

	// a pinned or unresolved particle A keeps its x position and y previous position
	a_a_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome != cpcr_pkg::OUT_RESOLVED || item_s9.fixed_flags[0])
		|-> new_pos_a_x == item_s9.pos_a_x && new_prev_a_y == item_s9.prev_a_y)
		else $error("particle A moved without a resolved contact");

	// a pinned or unresolved particle B keeps its y position and x previous position
	a_b_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome != cpcr_pkg::OUT_RESOLVED || item_s9.fixed_flags[1])
		|-> new_pos_b_y == item_s9.pos_b_y && new_prev_b_x == item_s9.prev_b_x)
		else $error("particle B moved without a resolved contact");

	// temperatures change only on a resolved contact
	a_temp_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outcome != cpcr_pkg::OUT_RESOLVED
		|-> new_temp_a == item_s9.temp_a && new_temp_b == item_s9.temp_b)
		else $error("temperature exchanged without a resolved contact");

endmodule

// ===== test/cpcr_checker.sv =====
// ----------------------------------------------------------------------------
// cpcr_checker
// Watches both channels of the collision resolve core, predicts each resolved
// pair from the accepted input and the mirrored registers, and compares.
// ----------------------------------------------------------------------------
module cpcr_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  cpcr_pkg::item_t       in_item,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic signed [31:0]    res [10],
	input  logic [1:0]            res_outcome,
	output int                    fail_count,
	output int                    pending,
	output int                    resolved_seen
);

	typedef struct {
		logic signed [31:0] f [10];
		logic [1:0]         oc;
	} pair_result_t;

	pair_result_t pair_q [$];
	logic [15:0]  m_eps;
	logic [15:0]  m_damp;
	logic [16:0]  m_rate;
	logic         m_fire;

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint scale_trunc(input longint a, input longint b, input int sh);
		longint unsigned ma, mb, m;
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		m = (ma * mb) >> sh;
		return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic pair_result_t resolve_pair(input cpcr_pkg::item_t it);
		pair_result_t p;
		longint v [10];
		longint dx, dy, cdist, ovl, nx, ny, amt, cx, cy, gap, t;
		longint unsigned sq;
		logic fa, fb;
		v[0] = it.pos_a_x; v[1] = it.pos_a_y; v[2] = it.prev_a_x; v[3] = it.prev_a_y;
		v[4] = it.pos_b_x; v[5] = it.pos_b_y; v[6] = it.prev_b_x; v[7] = it.prev_b_y;
		v[8] = it.temp_a;  v[9] = it.temp_b;
		fa = it.fixed_flags[0];
		fb = it.fixed_flags[1];
		dx = v[4] - v[0];
		dy = v[5] - v[1];
		if (dx == 0 && dy == 0) begin
			p.oc = cpcr_pkg::OUT_COINCIDENT;
		end else if ((dx < 0 ? -dx : dx) >= 64'sd2147483648
				|| (dy < 0 ? -dy : dy) >= 64'sd2147483648) begin
			p.oc = cpcr_pkg::OUT_NO_OVERLAP;
		end else begin
			sq = dx * dx + dy * dy;
			cdist = int_sqrt(sq);
			ovl = longint'(it.radius_sum) - cdist;
			if (cdist == 0 || ovl < longint'(m_eps)) begin
				p.oc = cpcr_pkg::OUT_NO_OVERLAP;
			end else begin
				nx = (dx * 65536) / cdist;
				ny = (dy * 65536) / cdist;
				amt = (fa || fb) ? ovl : (ovl >>> 1);
				cx = scale_trunc(nx, amt, 16);
				cy = scale_trunc(ny, amt, 16);
				p.oc = cpcr_pkg::OUT_RESOLVED;
				if (!fa) begin
					v[0] = clamp32(it.pos_a_x - cx);
					v[1] = clamp32(it.pos_a_y - cy);
					v[2] = clamp32(v[0] - scale_trunc(v[0] - it.prev_a_x, m_damp, 15));
					v[3] = clamp32(v[1] - scale_trunc(v[1] - it.prev_a_y, m_damp, 15));
				end
				if (!fb) begin
					v[4] = clamp32(it.pos_b_x + cx);
					v[5] = clamp32(it.pos_b_y + cy);
					v[6] = clamp32(v[4] - scale_trunc(v[4] - it.prev_b_x, m_damp, 15));
					v[7] = clamp32(v[5] - scale_trunc(v[5] - it.prev_b_y, m_damp, 15));
				end
				if (m_fire) begin
					gap = longint'(it.temp_a) - longint'(it.temp_b);
					if (gap > longint'(m_eps)) begin
						t = scale_trunc(gap >>> 1, m_rate, 16);
						v[8] = clamp32(v[8] - t);
						v[9] = clamp32(v[9] + t);
					end else if (-gap > longint'(m_eps)) begin
						t = scale_trunc((-gap) >>> 1, m_rate, 16);
						v[9] = clamp32(v[9] - t);
						v[8] = clamp32(v[8] + t);
					end
				end
			end
		end
		for (int i = 0; i < 10; i++) p.f[i] = v[i][31:0];
		return p;
	endfunction

	localparam string FIELD_NAME [10] = '{"new_pos_a_x", "new_pos_a_y", "new_prev_a_x",
		"new_prev_a_y", "new_pos_b_x", "new_pos_b_y", "new_prev_b_x", "new_prev_b_y",
		"new_temp_a", "new_temp_b"};

	assign pending = pair_q.size();

	always_ff @(posedge clk or negedge arst_n) begin
		pair_result_t want;
		int errs;
		if (!arst_n) begin
			m_eps <= 16'd66;
			m_damp <= 16'd32440;
			m_rate <= 17'd6554;
			m_fire <= 1'b0;
			fail_count <= 0;
			resolved_seen <= 0;
			pair_q.delete();
		end else begin
			errs = 0;
			if (psel && penable && pwrite && pready) begin
				case (cpcr_pkg::reg_idx_t'(paddr[3:2]))
					cpcr_pkg::REG_CONTACT_EPS:    m_eps <= pwdata[15:0];
					cpcr_pkg::REG_DAMPING:        m_damp <= pwdata[15:0];
					cpcr_pkg::REG_DIFFUSION_RATE: m_rate <= pwdata[16:0];
					cpcr_pkg::REG_FIRE_ENABLE:    m_fire <= pwdata[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				pair_q.push_back(resolve_pair(in_item));
			if (out_valid && out_ready) begin
				if (pair_q.size() == 0) begin
					$error("result with nothing expected");
					errs++;
				end else begin
					want = pair_q.pop_front();
					if (want.oc == cpcr_pkg::OUT_RESOLVED)
						resolved_seen <= resolved_seen + 1;
					for (int i = 0; i < 10; i++)
						if (res[i] !== want.f[i]) begin
							$error("%s expected %0d actual %0d", FIELD_NAME[i],
								want.f[i], res[i]);
							errs++;
						end
					if (res_outcome !== want.oc) begin
						$error("outcome expected %0d actual %0d", want.oc, res_outcome);
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end

endmodule

// ===== test/tb_circle_pair_collision_resolve_core.sv =====
// ----------------------------------------------------------------------------
// tb_circle_pair_collision_resolve_core
// Drives particle pairs and register settings into the collision resolve core
// under several idle patterns; a checker beside it predicts every result.
// ----------------------------------------------------------------------------
module tb_circle_pair_collision_resolve_core;

	localparam int DRAIN_CYCLES = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [cpcr_pkg::ADDR_W-1:0] paddr = '0;
	logic [cpcr_pkg::DATA_W-1:0] pwdata = '0;
	logic [cpcr_pkg::DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0, in_ready;
	cpcr_pkg::item_t pair_in = '0;
	logic out_valid, out_ready = 1'b0;
	logic signed [31:0] res [10];
	logic [1:0] outcome;
	int fail_count, pending, resolved_seen;
	int send_idle_pct = 0, recv_stall_pct = 0;
	int sent = 0;

	always #10 clk = ~clk;

	circle_pair_collision_resolve_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.pos_a_x(pair_in.pos_a_x), .pos_a_y(pair_in.pos_a_y),
		.prev_a_x(pair_in.prev_a_x), .prev_a_y(pair_in.prev_a_y),
		.pos_b_x(pair_in.pos_b_x), .pos_b_y(pair_in.pos_b_y),
		.prev_b_x(pair_in.prev_b_x), .prev_b_y(pair_in.prev_b_y),
		.radius_sum(pair_in.radius_sum), .fixed_flags(pair_in.fixed_flags),
		.temp_a(pair_in.temp_a), .temp_b(pair_in.temp_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.new_pos_a_x(res[0]), .new_pos_a_y(res[1]),
		.new_prev_a_x(res[2]), .new_prev_a_y(res[3]),
		.new_pos_b_x(res[4]), .new_pos_b_y(res[5]),
		.new_prev_b_x(res[6]), .new_prev_b_y(res[7]),
		.new_temp_a(res[8]), .new_temp_b(res[9]),
		.outcome(outcome)
	);

	cpcr_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(pair_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.res(res), .res_outcome(outcome),
		.fail_count(fail_count), .pending(pending), .resolved_seen(resolved_seen)
	);

	// Stall the receiver at random, redrawn every cycle.
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	// Hard stop: generous bound over the slowest correct run.
	initial begin
		#(20 * 2000000);
		$display("== FAIL ==");
		$finish;
	end

	// Write one register: setup cycle, then access cycle.
	task automatic write_reg(input cpcr_pkg::reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// Drop valid, wait out every expected result, then let the pipeline go quiet.
	task automatic drain_pipe();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Present one pair; hold it until accepted. Idle gaps come first, and
	// with none the next pair follows in the cycle right after acceptance.
	task automatic send_pair(input cpcr_pkg::item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pair_in <= it;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			default: return $urandom();
		endcase
	endfunction

	// A pair in or near contact: B placed near A with small offsets.
	function automatic cpcr_pkg::item_t near_pair();
		cpcr_pkg::item_t it;
		int span;
		span = 1 << $urandom_range(8, 22);
		it.pos_a_x = $urandom() >>> $urandom_range(1, 8);
		it.pos_a_y = $urandom() >>> $urandom_range(1, 8);
		if ($urandom_range(1)) it.pos_a_x = -it.pos_a_x;
		it.pos_b_x = it.pos_a_x + $signed($urandom_range(2 * span)) - span;
		it.pos_b_y = it.pos_a_y + $signed($urandom_range(2 * span)) - span;
		it.prev_a_x = it.pos_a_x + $signed($urandom_range(8192)) - 4096;
		it.prev_a_y = it.pos_a_y + $signed($urandom_range(8192)) - 4096;
		it.prev_b_x = it.pos_b_x + $signed($urandom_range(8192)) - 4096;
		it.prev_b_y = it.pos_b_y + $signed($urandom_range(8192)) - 4096;
		it.radius_sum = 31'($urandom_range(3 * span));
		it.fixed_flags = 2'($urandom_range(3));
		it.temp_a = rand_word();
		it.temp_b = $urandom_range(3) == 0 ? it.temp_a + $urandom_range(200) : rand_word();
		return it;
	endfunction

	function automatic cpcr_pkg::item_t noise_pair();
		cpcr_pkg::item_t it;
		it.pos_a_x = rand_word(); it.pos_a_y = rand_word();
		it.prev_a_x = rand_word(); it.prev_a_y = rand_word();
		it.pos_b_x = rand_word(); it.pos_b_y = rand_word();
		it.prev_b_x = rand_word(); it.prev_b_y = rand_word();
		it.radius_sum = $urandom_range(1) ? 31'h7FFFFFFF : 31'($urandom());
		it.fixed_flags = 2'($urandom_range(3));
		it.temp_a = rand_word(); it.temp_b = rand_word();
		return it;
	endfunction

	initial begin
		cpcr_pkg::item_t it;
		int phase_pct [4][2] = '{'{0, 0}, '{82, 0}, '{0, 82}, '{29, 29}};
		logic [31:0] eps_set [4] = '{0, 66, 65535, 1000};
		logic [31:0] damp_set [4] = '{32440, 0, 32768, 65535};
		logic [31:0] rate_set [4] = '{6554, 65536, 0, 131071};
		// Hold reset, then release once.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, coincident and overlapping pairs, flags, heat.
		write_reg(cpcr_pkg::REG_FIRE_ENABLE, 1);
		it = '0;
		send_pair(it);                                   // coincident centres
		it.pos_b_x = 32'sh00010000; it.radius_sum = 31'h00030000;
		for (int f = 0; f < 4; f++) begin                // every fixed combination
			it.fixed_flags = 2'(f);
			it.temp_a = 32'sh7FFFFFFF; it.temp_b = 32'sh80000000;
			send_pair(it);
		end
		it.fixed_flags = 0; it.temp_a = 100; it.temp_b = 40;
		send_pair(it);                                   // heat gap below epsilon
		it.temp_a = 32'sh80000000; it.temp_b = 32'sh7FFFFFFF;
		send_pair(it);
		it.pos_a_x = 32'sh80000000; it.pos_b_x = 32'sh7FFFFFFF;
		send_pair(it);                                   // distance beyond range
		it.pos_a_x = 32'sh7FFFFF00; it.pos_b_x = 32'sh7FFFFFF0;
		it.prev_a_x = 32'sh80000000; it.prev_b_x = 32'sh80000000;
		it.radius_sum = 31'h7FFFFFFF;
		send_pair(it);                                   // saturating move
		it = '0; it.pos_b_y = 1; it.radius_sum = 31'h7FFFFFFF;
		send_pair(it);                                   // minimal distance
		it.pos_b_y = 32'sh00020000; it.radius_sum = 31'h00020000;
		send_pair(it);                                   // touching, no overlap
		drain_pipe();

		// Random phases, each with its own register setting and one of four idle patterns.
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(cpcr_pkg::REG_CONTACT_EPS, eps_set[ph % 4]);
			write_reg(cpcr_pkg::REG_DAMPING, damp_set[(ph + ph / 4) % 4]);
			write_reg(cpcr_pkg::REG_DIFFUSION_RATE, rate_set[ph % 4]);
			write_reg(cpcr_pkg::REG_FIRE_ENABLE, ((ph % 3) != 0) ? 32'd1 : 32'd0);
			send_idle_pct = phase_pct[ph % 4][0];
			recv_stall_pct = phase_pct[ph % 4][1];
			for (int k = 0; k < 175; k++) begin
				send_pair($urandom_range(9) < 8 ? near_pair() : noise_pair());
				// Let the pipeline empty once mid-phase.
				if (k == 90)
					drain_pipe();
			end
			drain_pipe();
		end

		$display("Ran %0d pairs across 8 register settings, %0d resolved contacts.",
			sent, resolved_seen);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
